@@ src/lslf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Least-squares line fit: shared definitions
// Field widths, stream packing and fixed constants used by the line fitter.
// ----------------------------------------------------------------------------
package lslf_pkg;

   // Width of each coordinate field on the point stream.
   localparam int COORD_W = 16;

   // Point stream tdata: x_coord in the low half, y_coord above it.
   localparam int REQ_DATA_W = 2 * COORD_W;

   // Result stream tdata layout, lowest bit first.
   localparam int RES_W       = 32;
   localparam int TOTAL_W     = 7;
   localparam int SLOPE_LSB   = 0;
   localparam int ICPT_LSB    = SLOPE_LSB + RES_W;
   localparam int OK_BIT      = ICPT_LSB + RES_W;
   localparam int OVF_BIT     = OK_BIT + 1;
   localparam int TOTAL_LSB   = OVF_BIT + 1;
   localparam int RSP_USED_W  = TOTAL_LSB + TOTAL_W;
   localparam int RSP_DATA_W  = ((RSP_USED_W + 7) / 8) * 8;

   // Scaling of the two numerators ahead of the division.
   localparam int SLOPE_SHIFT = 16;
   localparam int ICPT_SHIFT  = 4;

   // Result values for a degenerate fit and the saturation limits.
   localparam logic [RES_W-1:0] DEFAULT_SLOPE = 32'h0001_0000;
   localparam logic [RES_W-1:0] DEFAULT_ICPT  = 32'h0000_0000;
   localparam logic [RES_W-1:0] SAT_POS       = 32'h7FFF_FFFF;
   localparam logic [RES_W-1:0] SAT_NEG       = 32'h8000_0000;

endpackage : lslf_pkg
`default_nettype wire

@@ src/least_squares_line_fit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Least-squares line fit
// Accumulates point sums and fits y = a*x + b at the end of each point set.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake           Payload
// -------   ---------  ------------------  -----------------------------------
// req_      in         tvalid / tready     tdata: x_coord, y_coord; tlast: last
// rsp_      out        tvalid / tready     tdata: slope, intercept, fit_ok,
//                                          point_overflow, point_total
//
// An ordinary point needs no sequencer step: the running sums sit in
// registers and are updated the cycle the transaction is accepted.
// The point marked last starts the fit, which forms its products,
// differences and quotients on one shared adder / subtractor under a small
// sequencer: six shift-add multiplies, three to five subtractions, two
// restoring divisions and one hand-off step. A set with a zero denominator
// stops after the first two products. req_tready is low for that whole
// time. The finished result waits in an output register, so the next set
// can be accumulated while rsp_ is stalled; the next fit then holds in
// its final step until the register is free.
// Reset is synchronous and active high; it clears the sums and the sequencer.
// ----------------------------------------------------------------------------
module least_squares_line_fit
   import lslf_pkg::*;
#(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   // Point stream.
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire [REQ_DATA_W-1:0]   req_tdata,  // x_coord[15:0], y_coord[31:16]
   input  wire                    req_tlast,  // last_point
   // Result stream.
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata   // slope[31:0], intercept[63:32],
                                              // fit_ok[64], point_overflow[65],
                                              // point_total[72:66], zero pad
);

   // Only the low COORD_BITS bits of each coordinate take part.
   localparam int CW    = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
   localparam int NW    = $clog2(MAX_POINTS + 1);  // point counter
   localparam int SXW   = CW + NW;                 // sum_x, sum_y
   localparam int SXXW  = 2 * CW + NW;             // sum_x_squared, sum_x_times_y
   localparam int PW    = SXW + SXXW;              // widest product
   localparam int BW    = 2 * SXW;                 // denominator
   localparam int NUMA  = BW + SLOPE_SHIFT;
   localparam int NUMB  = PW + ICPT_SHIFT;
   localparam int NUMW  = (NUMA > NUMB) ? NUMA : NUMB;
   localparam int CNTW  = $clog2(NUMW + 1);
   localparam int QW    = RES_W + 1;               // kept quotient bits

   typedef enum logic [2:0] {
      ST_ACC,    // taking points
      ST_LOAD,   // load multiplier operands
      ST_MUL,    // shift-add multiply
      ST_SUB,    // first product minus second
      ST_NEG,    // second minus first when negative
      ST_DIV,    // restoring division
      ST_ROUND,  // round to nearest and saturate
      ST_DONE    // hand result to the output register
   } state_type;

   // Products needed by the fit, in the order they are formed.
   typedef enum logic [2:0] {
      STEP_N_SXX,
      STEP_SX_SX,
      STEP_N_SXY,
      STEP_SX_SY,
      STEP_SXX_SY,
      STEP_SX_SXY
   } step_type;

   state_type             state_ff, state_in;
   step_type              step_ff, step_in;

   logic [SXXW-1:0]       sxx_ff, sxx_in;
   logic [SXW-1:0]        sx_ff, sx_in;
   logic [SXXW-1:0]       sxy_ff, sxy_in;
   logic [SXW-1:0]        sy_ff, sy_in;
   logic [NW-1:0]         npts_ff, npts_in;
   logic                  drop_ff, drop_in;

   logic [PW-1:0]         acc_ff, acc_in;
   logic [PW-1:0]         hold_ff, hold_in;
   logic [SXW-1:0]        mula_ff, mula_in;
   logic [SXXW-1:0]       mulb_ff, mulb_in;
   logic [CNTW-1:0]       cnt_ff, cnt_in;
   logic [BW-1:0]         bot_ff, bot_in;
   logic [NUMW-1:0]       num_ff, num_in;
   logic                  neg_ff, neg_in;
   logic [BW-1:0]         rem_ff, rem_in;
   logic [QW-1:0]         quo_ff, quo_in;
   logic                  qovf_ff, qovf_in;
   logic [RES_W-1:0]      slope_ff, slope_in;
   logic [RES_W-1:0]      icpt_ff, icpt_in;
   logic                  ok_ff, ok_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Point datapath.
   logic [CW-1:0]         x_pt, y_pt;
   logic [2*CW-1:0]       xx_prod, xy_prod;
   logic                  pt_accept;

   // Shared adder / subtractor.
   logic [PW-1:0]         alu_a, alu_b;
   logic                  alu_sub;
   logic [PW:0]           alu_sum;
   logic                  alu_carry;
   logic [PW-1:0]         alu_diff;

   // Operand views.
   logic [SXW-1:0]        n_ext;
   logic [NUMW-1:0]       num_base;
   logic [QW:0]           q_round;
   logic [RES_W-1:0]      q_result;
   logic                  out_free;
   logic [NW+TOTAL_W-1:0] total_wide;

   assign x_pt      = req_tdata[CW-1:0];
   assign y_pt      = req_tdata[COORD_W+CW-1:COORD_W];
   assign xx_prod   = x_pt * x_pt;
   assign xy_prod   = x_pt * y_pt;
   assign req_tready = (state_ff == ST_ACC);
   assign pt_accept = req_tvalid && req_tready;

   assign n_ext     = {{CW{1'b0}}, npts_ff};
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign total_wide = {{TOTAL_W{1'b0}}, npts_ff};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The one arithmetic unit: a + b, or a - b with carry meaning a >= b.
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff)
         ST_MUL: begin
            alu_a = {acc_ff[PW-2:0], 1'b0};
            alu_b = mula_ff[SXW-1] ? {{SXW{1'b0}}, mulb_ff} : '0;
         end
         ST_SUB: begin
            alu_a   = hold_ff;
            alu_b   = acc_ff;
            alu_sub = 1'b1;
         end
         ST_NEG: begin
            alu_a   = acc_ff;
            alu_b   = hold_ff;
            alu_sub = 1'b1;
         end
         ST_DIV: begin
            alu_a   = {{(PW-BW-1){1'b0}}, rem_ff, num_ff[NUMW-1]};
            alu_b   = {{(PW-BW){1'b0}}, bot_ff};
            alu_sub = 1'b1;
         end
         ST_ROUND: begin
            alu_a   = {{(PW-BW-1){1'b0}}, rem_ff, 1'b0};
            alu_b   = {{(PW-BW){1'b0}}, bot_ff};
            alu_sub = 1'b1;
         end
         default: begin
            alu_a   = '0;
            alu_b   = '0;
            alu_sub = 1'b0;
         end
      endcase
      alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                  + {{PW{1'b0}}, alu_sub};
      alu_carry = alu_sum[PW];
      alu_diff  = alu_sum[PW-1:0];
   end

   // Rounding (remainder at least half the divisor) and saturation.
   always_comb begin
      q_round = {1'b0, quo_ff} + {{QW{1'b0}}, alu_carry};
      if (!neg_ff) begin
         if (qovf_ff || (q_round > {{(QW+1-RES_W){1'b0}}, SAT_POS})) begin
            q_result = SAT_POS;
         end else begin
            q_result = q_round[RES_W-1:0];
         end
      end else begin
         if (qovf_ff || (q_round > {{(QW+1-RES_W){1'b0}}, SAT_NEG})) begin
            q_result = SAT_NEG;
         end else begin
            q_result = {RES_W{1'b0}} - q_round[RES_W-1:0];
         end
      end
   end

   // Numerator taken from the absolute difference just formed.
   assign num_base = {{(NUMW-PW){1'b0}}, alu_diff};

   // Sequencer and datapath next values.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      sxx_in       = sxx_ff;
      sx_in        = sx_ff;
      sxy_in       = sxy_ff;
      sy_in        = sy_ff;
      npts_in      = npts_ff;
      drop_in      = drop_ff;
      acc_in       = acc_ff;
      hold_in      = hold_ff;
      mula_in      = mula_ff;
      mulb_in      = mulb_ff;
      cnt_in       = cnt_ff;
      bot_in       = bot_ff;
      num_in       = num_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      qovf_in      = qovf_ff;
      slope_in     = slope_ff;
      icpt_in      = icpt_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_ACC: begin
            if (pt_accept) begin
               if (npts_ff != NW'(MAX_POINTS)) begin
                  sxx_in  = sxx_ff + {{NW{1'b0}}, xx_prod};
                  sx_in   = sx_ff + {{NW{1'b0}}, x_pt};
                  sxy_in  = sxy_ff + {{NW{1'b0}}, xy_prod};
                  sy_in   = sy_ff + {{NW{1'b0}}, y_pt};
                  npts_in = npts_ff + NW'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_tlast) begin
                  step_in  = STEP_N_SXX;
                  state_in = ST_LOAD;
               end
            end
         end

         ST_LOAD: begin
            acc_in = '0;
            cnt_in = CNTW'(SXW);
            unique case (step_ff)
               STEP_N_SXX: begin
                  mula_in = n_ext;
                  mulb_in = sxx_ff;
               end
               STEP_SX_SX: begin
                  mula_in = sx_ff;
                  mulb_in = {{CW{1'b0}}, sx_ff};
               end
               STEP_N_SXY: begin
                  mula_in = n_ext;
                  mulb_in = sxy_ff;
               end
               STEP_SX_SY: begin
                  mula_in = sx_ff;
                  mulb_in = {{CW{1'b0}}, sy_ff};
               end
               STEP_SXX_SY: begin
                  mula_in = sy_ff;
                  mulb_in = sxx_ff;
               end
               STEP_SX_SXY: begin
                  mula_in = sx_ff;
                  mulb_in = sxy_ff;
               end
               default: begin
                  mula_in = sx_ff;
                  mulb_in = sxy_ff;
               end
            endcase
            state_in = ST_MUL;
         end

         ST_MUL: begin
            // Multiplier bits are consumed from the top down.
            acc_in  = alu_diff;
            mula_in = {mula_ff[SXW-2:0], 1'b0};
            cnt_in  = cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) begin
               priority case (step_ff)
                  STEP_N_SXX: begin
                     hold_in  = alu_diff;
                     step_in  = STEP_SX_SX;
                     state_in = ST_LOAD;
                  end
                  STEP_N_SXY: begin
                     hold_in  = alu_diff;
                     step_in  = STEP_SX_SY;
                     state_in = ST_LOAD;
                  end
                  STEP_SXX_SY: begin
                     hold_in  = alu_diff;
                     step_in  = STEP_SX_SXY;
                     state_in = ST_LOAD;
                  end
                  default: begin
                     state_in = ST_SUB;
                  end
               endcase
            end
         end

         ST_SUB: begin
            if (step_ff == STEP_SX_SX) begin
               // A denominator of zero means one point or all x equal.
               if (!alu_carry || (alu_diff == '0)) begin
                  slope_in = DEFAULT_SLOPE;
                  icpt_in  = DEFAULT_ICPT;
                  ok_in    = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  bot_in   = alu_diff[BW-1:0];
                  step_in  = STEP_N_SXY;
                  state_in = ST_LOAD;
               end
            end else if (alu_carry) begin
               neg_in   = 1'b0;
               num_in   = (step_ff == STEP_SX_SY) ? (num_base << SLOPE_SHIFT)
                                                  : (num_base << ICPT_SHIFT);
               rem_in   = '0;
               quo_in   = '0;
               qovf_in  = 1'b0;
               cnt_in   = CNTW'(NUMW);
               state_in = ST_DIV;
            end else begin
               state_in = ST_NEG;
            end
         end

         ST_NEG: begin
            neg_in   = 1'b1;
            num_in   = (step_ff == STEP_SX_SY) ? (num_base << SLOPE_SHIFT)
                                               : (num_base << ICPT_SHIFT);
            rem_in   = '0;
            quo_in   = '0;
            qovf_in  = 1'b0;
            cnt_in   = CNTW'(NUMW);
            state_in = ST_DIV;
         end

         ST_DIV: begin
            // One quotient bit per cycle; bits above the kept ones only
            // matter as a saturation flag.
            rem_in  = alu_carry ? alu_diff[BW-1:0] : alu_a[BW-1:0];
            num_in  = {num_ff[NUMW-2:0], 1'b0};
            qovf_in = qovf_ff | quo_ff[QW-1];
            quo_in  = {quo_ff[QW-2:0], alu_carry};
            cnt_in  = cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) begin
               state_in = ST_ROUND;
            end
         end

         ST_ROUND: begin
            if (step_ff == STEP_SX_SY) begin
               slope_in = q_result;
               step_in  = STEP_SXX_SY;
               state_in = ST_LOAD;
            end else begin
               icpt_in  = q_result;
               ok_in    = 1'b1;
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[SLOPE_LSB +: RES_W]   = slope_ff;
               rsp_data_in[ICPT_LSB +: RES_W]    = icpt_ff;
               rsp_data_in[OK_BIT]               = ok_ff;
               rsp_data_in[OVF_BIT]              = drop_ff;
               rsp_data_in[TOTAL_LSB +: TOTAL_W] = total_wide[TOTAL_W-1:0];
               sxx_in   = '0;
               sx_in    = '0;
               sxy_in   = '0;
               sy_in    = '0;
               npts_in  = '0;
               drop_in  = 1'b0;
               state_in = ST_ACC;
            end
         end

         default: begin
            state_in = ST_ACC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACC;
         step_ff      <= STEP_N_SXX;
         sxx_ff       <= '0;
         sx_ff        <= '0;
         sxy_ff       <= '0;
         sy_ff        <= '0;
         npts_ff      <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         sxx_ff       <= sxx_in;
         sx_ff        <= sx_in;
         sxy_ff       <= sxy_in;
         sy_ff        <= sy_in;
         npts_ff      <= npts_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff      <= acc_in;
      hold_ff     <= hold_in;
      mula_ff     <= mula_in;
      mulb_ff     <= mulb_in;
      cnt_ff      <= cnt_in;
      bot_ff      <= bot_in;
      num_ff      <= num_in;
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      qovf_ff     <= qovf_in;
      slope_ff    <= slope_in;
      icpt_ff     <= icpt_in;
      ok_ff       <= ok_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule : least_squares_line_fit
`default_nettype wire

@@ tb/sv/lslf_fit_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line fitter result checker
// Watches the point and result streams of the line fitter. It keeps its own
// running sums, works out each expected fit when a set closes, and compares
// every result transaction with the oldest fit still waiting.
// ----------------------------------------------------------------------------
module lslf_fit_checker
   import lslf_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   input  wire                    req_tready,
   input  wire [REQ_DATA_W-1:0]   req_tdata,  // x_coord[15:0], y_coord[31:16]
   input  wire                    req_tlast,  // last_point
   input  wire                    rsp_tvalid,
   input  wire                    rsp_tready,
   input  wire [RSP_DATA_W-1:0]   rsp_tdata,  // slope, intercept, fit_ok,
                                              // point_overflow, point_total
   output int                     fit_errors,
   output int                     fits_waiting
);

   localparam int MAX_POINTS = 64;
   // The block holds at most two finished or finishing fits at a time.
   localparam int FIT_SLOTS  = 8;

   typedef struct packed {
      logic [RES_W-1:0]   slope;
      logic [RES_W-1:0]   intercept;
      logic               fit_ok;
      logic               point_overflow;
      logic [TOTAL_W-1:0] point_total;
   } line_fit_type;

   logic [63:0]  sum_xx, sum_x, sum_xy, sum_y;
   int unsigned  n_points;
   logic         dropped;
   line_fit_type fits_due [FIT_SLOTS];
   int           fit_head, fit_tail, fit_count;
   int           error_total;

   // Quotient rounded to nearest with ties away from zero, then clipped to
   // the signed 32-bit range. The magnitude and sign arrive separately.
   function automatic logic [RES_W-1:0] divide_round_sat(input logic [127:0] mag,
                                                         input logic neg,
                                                         input logic [127:0] den);
      logic [127:0] quo, rem;
      quo = mag / den;
      rem = mag % den;
      if (rem >= den - rem) quo = quo + 128'd1;
      if (!neg) return (quo > 128'h7FFF_FFFF) ? SAT_POS : quo[RES_W-1:0];
      return (quo > 128'h8000_0000) ? SAT_NEG : 32'd0 - quo[RES_W-1:0];
   endfunction

   // Solves the normal equations over the current sums. All products are
   // exact at 128 bits; the intercept numerator can pass 64 bits.
   function automatic line_fit_type solve_fit();
      logic [127:0] n, sxx, sx, sxy, sy, t1, t2, den, p, m, mag;
      logic         neg;
      line_fit_type f;
      n   = 128'(n_points);
      sxx = 128'(sum_xx);
      sx  = 128'(sum_x);
      sxy = 128'(sum_xy);
      sy  = 128'(sum_y);
      f.slope          = DEFAULT_SLOPE;
      f.intercept      = DEFAULT_ICPT;
      f.fit_ok         = 1'b0;
      f.point_overflow = dropped;
      f.point_total    = n_points[TOTAL_W-1:0];
      t1 = n * sxx;
      t2 = sx * sx;
      if (t1 > t2) begin
         den = t1 - t2;
         p   = n * sxy;
         m   = sx * sy;
         neg = p < m;
         mag = neg ? m - p : p - m;
         f.slope = divide_round_sat(mag << SLOPE_SHIFT, neg, den);
         p   = sxx * sy;
         m   = sx * sxy;
         neg = p < m;
         mag = neg ? m - p : p - m;
         f.intercept = divide_round_sat(mag << ICPT_SHIFT, neg, den);
         f.fit_ok    = 1'b1;
      end
      return f;
   endfunction

   always @(posedge clock) begin
      line_fit_type           want, got;
      logic                   bad;
      logic [COORD_W-1:0]     px, py;
      if (reset) begin
         sum_xx = '0;
         sum_x  = '0;
         sum_xy = '0;
         sum_y  = '0;
         n_points = 0;
         dropped  = 1'b0;
         fit_head  = 0;
         fit_tail  = 0;
         fit_count = 0;
         error_total = 0;
         fit_errors   <= 0;
         fits_waiting <= 0;
      end else begin
         // Results are taken first; a fit never leaves in the cycle its set closes.
         if (rsp_tvalid && rsp_tready) begin
            got.slope          = rsp_tdata[SLOPE_LSB +: RES_W];
            got.intercept      = rsp_tdata[ICPT_LSB +: RES_W];
            got.fit_ok         = rsp_tdata[OK_BIT];
            got.point_overflow = rsp_tdata[OVF_BIT];
            got.point_total    = rsp_tdata[TOTAL_LSB +: TOTAL_W];
            if (fit_count == 0) begin
               error_total++;
               if (error_total <= 10)
                  $display("unexpected fit result: slope %h intercept %h ok %b ovf %b n %0d",
                           got.slope, got.intercept, got.fit_ok, got.point_overflow,
                           got.point_total);
            end else begin
               want = fits_due[fit_head];
               fit_head = (fit_head + 1) % FIT_SLOTS;
               fit_count--;
               bad = (got.slope !== want.slope) || (got.intercept !== want.intercept) ||
                     (got.fit_ok !== want.fit_ok) ||
                     (got.point_overflow !== want.point_overflow) ||
                     (got.point_total !== want.point_total);
               if (bad) begin
                  error_total++;
                  if (error_total <= 10) begin
                     $display("fit mismatch: slope exp %h got %h, intercept exp %h got %h",
                              want.slope, got.slope, want.intercept, got.intercept);
                     $display("   fit_ok exp %b got %b, overflow exp %b got %b, n exp %0d got %0d",
                              want.fit_ok, got.fit_ok, want.point_overflow,
                              got.point_overflow, want.point_total, got.point_total);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            px = req_tdata[COORD_W-1:0];
            py = req_tdata[REQ_DATA_W-1:COORD_W];
            if (n_points < MAX_POINTS) begin
               sum_xx += 64'(px) * 64'(px);
               sum_x  += 64'(px);
               sum_xy += 64'(px) * 64'(py);
               sum_y  += 64'(py);
               n_points++;
            end else begin
               dropped = 1'b1;
            end
            if (req_tlast) begin
               if (fit_count == FIT_SLOTS) begin
                  // The block took a new set while too many fits were unread.
                  error_total++;
                  if (error_total <= 10)
                     $display("fit backlog: expected at most %0d pending, got more",
                              FIT_SLOTS);
               end else begin
                  fits_due[fit_tail] = solve_fit();
                  fit_tail = (fit_tail + 1) % FIT_SLOTS;
                  fit_count++;
               end
               sum_xx = '0;
               sum_x  = '0;
               sum_xy = '0;
               sum_y  = '0;
               n_points = 0;
               dropped  = 1'b0;
            end
         end
         fit_errors   <= error_total;
         fits_waiting <= fit_count;
      end
   end

endmodule : lslf_fit_checker

@@ tb/sv/least_squares_line_fit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line fitter testbench
// Streams sets of points into the least-squares line fitter under several
// patterns of sender gaps and receiver stalls. A checker beside the block
// predicts every fit and counts mismatches; this module only makes stimulus
// and gives the verdict.
// ----------------------------------------------------------------------------
module least_squares_line_fit_tb;
   import lslf_pkg::*;

   // Generous ceiling: even if every point closed a set, the fits plus sender
   // gaps and receiver stalls stay well under this figure.
   localparam int CYCLE_LIMIT = 2_000_000;

   // Kinds of point sets the random part draws from.
   typedef enum int {
      SHAPE_SCATTER,    // x and y anywhere in the full range
      SHAPE_LINE,       // points near a straight line, small noise
      SHAPE_VERTICAL,   // every x equal: zero denominator
      SHAPE_TINY        // coordinates within a few LSBs of zero
   } set_shape_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;     // x_coord[15:0], y_coord[31:16]
   logic                   req_tlast = 1'b0;   // last_point
   wire                    req_tready;
   wire                    rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   wire  [RSP_DATA_W-1:0]  rsp_tdata;          // slope, intercept, fit_ok,
                                               // point_overflow, point_total

   int fit_errors;
   int fits_waiting;

   // Knobs shared between the stimulus and the receiver process.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_request   = 0;
   int points_sent    = 0;
   int cycle_count    = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   least_squares_line_fit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   lslf_fit_checker fit_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .fit_errors   (fit_errors),
      .fits_waiting (fits_waiting)
   );

   // Receiver. Each falling edge it decides whether to take a result in the
   // coming cycle. A hold request from the stimulus is copied into a local
   // count so that the long stall is timed here, independent of the sender.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog: a hung handshake or a missing result ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("least_squares_line_fit verification failed");
      $finish;
   end

   // Offers one point and returns at the falling edge after the transaction.
   // Sender gaps are inserted ahead of the point; when there is no gap, valid
   // simply stays high into the next point.
   task automatic put_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      points_sent++;
   endtask

   // Stops offering points and waits for every predicted fit to come out.
   task automatic drain_fits();
      req_tvalid <= 1'b0;
      wait (fits_waiting == 0);
      @(negedge clock);
   endtask

   // Mostly short sets; a few single points, some mid-size sets and now and
   // then a set long enough to run past the 64-point capacity.
   function automatic int pick_set_length();
      int r;
      r = $urandom_range(99);
      if (r < 10) return 1;
      if (r < 85) return $urandom_range(2, 12);
      if (r < 96) return $urandom_range(13, 40);
      return $urandom_range(60, 70);
   endfunction

   function automatic set_shape_type pick_shape();
      int r;
      r = $urandom_range(99);
      if (r < 40) return SHAPE_SCATTER;
      if (r < 75) return SHAPE_LINE;
      if (r < 85) return SHAPE_VERTICAL;
      return SHAPE_TINY;
   endfunction

   // Sends one complete set; only its final point carries tlast.
   task automatic send_set(input int len, input set_shape_type shape);
      int                 i, xi, yi, base_x, step, gain, offset, fixed_x;
      logic [COORD_W-1:0] x, y;
      base_x  = $urandom_range(0, 32767);
      step    = $urandom_range(1, 512);
      gain    = int'($urandom_range(16)) - 8;
      offset  = $urandom_range(0, 65535);
      fixed_x = $urandom_range(0, 65535);
      for (i = 0; i < len; i++) begin
         unique case (shape)
            SHAPE_SCATTER: begin
               x = COORD_W'($urandom_range(0, 65535));
               y = COORD_W'($urandom_range(0, 65535));
            end
            SHAPE_LINE: begin
               xi = base_x + i * step;
               if (xi > 65535) xi = 65535;
               // Slope between -2 and +2 in quarter steps, plus a little noise.
               yi = offset + (gain * xi) / 4 + int'($urandom_range(16)) - 8;
               if (yi < 0) yi = 0;
               if (yi > 65535) yi = 65535;
               x = xi[COORD_W-1:0];
               y = yi[COORD_W-1:0];
            end
            SHAPE_VERTICAL: begin
               x = fixed_x[COORD_W-1:0];
               y = COORD_W'($urandom_range(0, 65535));
            end
            default: begin
               x = COORD_W'($urandom_range(0, 15));
               y = COORD_W'($urandom_range(0, 15));
            end
         endcase
         put_point(x, y, i == len - 1);
      end
   endtask

   // One stretch of random sets under a fixed idling pattern. The phase ends
   // only when every fit has been delivered, so the next pattern starts clean.
   task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
      int target;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      target = points_sent + count;
      while (points_sent < target) send_set(pick_set_length(), pick_shape());
      drain_fits();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed sets, sent back to back with a receiver that never stalls.
      // A lone point leaves the denominator at zero.
      put_point(16'd0, 16'd0, 1'b1);
      // Two points on one vertical line at the top of the x range.
      put_point(16'hFFFF, 16'd0, 1'b0);
      put_point(16'hFFFF, 16'hFFFF, 1'b1);
      // Unit slope across the whole range, through the origin.
      put_point(16'd0, 16'd0, 1'b0);
      put_point(16'hFFFF, 16'hFFFF, 1'b1);
      // Falling diagonal: slope -1.0 and the largest positive intercept that fits.
      put_point(16'd0, 16'hFFFF, 1'b0);
      put_point(16'hFFFF, 16'd0, 1'b1);
      // Level line: the slope numerator is exactly zero.
      put_point(16'd0, 16'd4660, 1'b0);
      put_point(16'd4096, 16'd4660, 1'b1);
      // One LSB of x for the full y span: the slope clips at the positive limit.
      put_point(16'd0, 16'd0, 1'b0);
      put_point(16'd1, 16'hFFFF, 1'b1);
      // The same, falling: the slope clips at the negative limit.
      put_point(16'd0, 16'hFFFF, 1'b0);
      put_point(16'd1, 16'd0, 1'b1);
      // Steep rise far out on x drives the intercept past the negative limit.
      put_point(16'hFFFE, 16'd0, 1'b0);
      put_point(16'hFFFF, 16'hFFFF, 1'b1);
      // Steep fall far out on x drives the intercept past the positive limit.
      put_point(16'hFFFE, 16'hFFFF, 1'b0);
      put_point(16'hFFFF, 16'd0, 1'b1);
      drain_fits();

      // Back pressure: the receiver holds off on a hold request while
      // sets keep coming. One fit parks in the output register, the next one
      // stalls in its last step, and the block then refuses further points.
      hold_request = 4000;
      repeat (4) send_set(8, SHAPE_SCATTER);
      drain_fits();

      // Random sets under each idling pattern in turn.
      run_phase(0, 0, 300);
      run_phase(87, 0, 300);
      run_phase(0, 87, 300);
      run_phase(25, 25, 300);

      // Give the block time to show any result it should not produce.
      repeat (600) @(posedge clock);
      if (fit_errors == 0 && fits_waiting == 0) begin
         $display("least_squares_line_fit verification clean");
      end else begin
         $display("least_squares_line_fit verification failed");
      end
      $finish;
   end

endmodule : least_squares_line_fit_tb
